/* design/alnr_pkg.sv */
// Shared types and constants for the adaptive local noise reduction unit.
package alnr_pkg;

   localparam int SUM_W   = 14;
   localparam int SQ_W    = 22;
   localparam int NV_W    = 16;
   localparam int PIX_W   = 8;
   localparam int CSR_W   = 16;
   localparam int IDX_W   = 2;
   localparam int RING_ROWS = 8;
   localparam int RING_W  = 3;

   localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [IDX_W-1:0] REG_NOISE  = 2'd2;

   localparam logic [10:0] WIDTH_RESET  = 11'd640;
   localparam logic [12:0] HEIGHT_RESET = 13'd480;
   localparam logic [15:0] NOISE_RESET  = 16'd1000;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] sum;
      logic [SQ_W-1:0]  sumsq;
      logic [PIX_W-1:0] center;
      logic [NV_W-1:0]  noise;
   } stat_req_type;

   typedef struct packed {
      logic             done;
      logic [PIX_W-1:0] value;
   } stat_rsp_type;

endpackage

/* design/alnr_if.sv */
// Handshake channel interfaces for samples in and filtered samples out.
interface alnr_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] sample;
   modport source (output valid, output opcode, output sample, input ready);
   modport sink (input valid, input opcode, input sample, output ready);
endinterface

interface alnr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_sample;
   logic       frame_end;
   modport source (output valid, output out_sample, output frame_end, input ready);
   modport sink (input valid, input out_sample, input frame_end, output ready);
endinterface

/* design/alnr_line_mem.sv */
// Line store memory with one write port and one registered read port.
module alnr_line_mem #(
   parameter int DEPTH = 8192,
   parameter int AW    = 13
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* design/alnr_stat.sv */
// Window statistics unit: mean, variance and the adaptive output with a serial divider.
module alnr_stat #(
   parameter int TAPS = 49
) (
   input  logic                 clock,
   input  logic                 reset,
   input  alnr_pkg::stat_req_type req,
   output alnr_pkg::stat_rsp_type rsp
);
   localparam int RECIP = (2**20 + TAPS - 1) / TAPS;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_MEAN = 8'b0000_0010,
      ST_DIFF = 8'b0000_0100,
      ST_VAR  = 8'b0000_1000,
      ST_PROD = 8'b0001_0000,
      ST_SUB  = 8'b0010_0000,
      ST_DIV  = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [13:0] sum_ff, sum_in;
   logic [21:0] sq_ff, sq_in;
   logic [7:0]  p_ff, p_in;
   logic [15:0] nv_ff, nv_in;
   logic [7:0]  m_ff, m_in;
   logic [14:0] d_ff, d_in;
   logic [21:0] s_ff, s_in;
   logic [21:0] gn_ff, gn_in;
   logic [29:0] a_ff, a_in;
   logic signed [31:0] b_ff, b_in;
   logic [31:0] rem_ff, rem_in;
   logic [2:0]  bit_ff, bit_in;
   logic [7:0]  q_ff, q_in;
   logic signed [32:0] num;
   logic [31:0] trial;
   logic [34:0] mprod;

   always_comb begin
      state_in = state_ff;
      sum_in = sum_ff; sq_in = sq_ff; p_in = p_ff; nv_in = nv_ff;
      m_in = m_ff; d_in = d_ff; s_in = s_ff; gn_in = gn_ff;
      a_in = a_ff; b_in = b_ff; rem_in = rem_ff; bit_in = bit_ff; q_in = q_ff;
      mprod = 35'(sum_ff) * 35'(RECIP);
      num = 33'(signed'({1'b0, a_ff})) - 33'(b_ff);
      trial = 32'(s_ff) << bit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.start) begin
               sum_in = req.sum; sq_in = req.sumsq; p_in = req.center; nv_in = req.noise;
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            m_in = 8'(mprod >> 20);
            gn_in = 22'(32'(nv_ff) * 32'(TAPS));
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            d_in = 15'({sum_ff, 1'b0} - 15'(32'(m_ff) * 32'(TAPS)));
            state_in = ST_VAR;
         end
         ST_VAR: begin
            s_in = sq_ff - 22'(23'(m_ff) * 23'(d_ff));
            state_in = ST_PROD;
         end
         ST_PROD: begin
            a_in = 30'(p_ff) * 30'(s_ff);
            b_in = 32'(signed'({10'b0, gn_ff})) * 32'(signed'({1'b0, p_ff}) - signed'({1'b0, m_ff}));
            state_in = ST_SUB;
         end
         ST_SUB: begin
            bit_in = 3'd7;
            q_in = 8'd0;
            rem_in = 32'(num);
            if (gn_ff > s_ff) begin
               q_in = m_ff;
               state_in = ST_DONE;
            end else if (s_ff == 22'd0) begin
               q_in = p_ff;
               state_in = ST_DONE;
            end else if (num < 0) begin
               state_in = ST_DONE;
            end else if (32'(num) >= (32'(s_ff) << 8)) begin
               q_in = 8'hFF;
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               q_in = q_ff | (8'd1 << bit_ff);
            end
            bit_in = bit_ff - 3'd1;
            if (bit_ff == 3'd0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      sum_ff <= sum_in; sq_ff <= sq_in; p_ff <= p_in; nv_ff <= nv_in;
      m_ff <= m_in; d_ff <= d_in; s_ff <= s_in; gn_ff <= gn_in;
      a_ff <= a_in; b_ff <= b_in; rem_ff <= rem_in; bit_ff <= bit_in; q_ff <= q_in;
   end

   assign rsp.done  = (state_ff == ST_DONE);
   assign rsp.value = q_ff;
endmodule

/* design/adaptive_local_noise_reduction_unit.sv */
// Top level of the adaptive local noise reduction filter.
//
// Samples arrive in raster order on the req_ch channel (opcode 0 carries a
// sample, opcode 1 is a flush transfer that only drains pending outputs).
// Filtered samples leave on rsp_ch in raster order with frame_end set on the
// last pixel of the frame. Each pixel uses a square window around it with
// edge replication, read from an eight-row line store memory.
// An input transfer that makes no output passes the check state and returns to
// idle. When it makes one, the block reads the window one entry a cycle, the
// single memory read port setting that rate; then the statistics unit finds mean,
// variance and the adaptive output with its serial divider before the result is emitted.
// The output register holds a result while the receiver stalls; the next
// transfer is still accepted and its result waits until the register frees.
// Reset clears positions and loads 640 x 480 with noise variance 1000; the
// line store holds no defined data until written. A write to the width, height or
// noise register restarts the frame and drops pending outputs.
module adaptive_local_noise_reduction_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int WINDOW     = 7
) (
   input  logic clock,
   input  logic reset,
   alnr_req_if.sink   req_ch,
   alnr_rsp_if.source rsp_ch,
   input  logic                       csr_we,
   input  logic [alnr_pkg::IDX_W-1:0] csr_index,
   input  logic [alnr_pkg::CSR_W-1:0] csr_wdata
);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int HALF  = WINDOW / 2;
   localparam int TAPS  = WINDOW * WINDOW;
   localparam int WW    = $clog2(WINDOW);
   localparam int DEPTH = alnr_pkg::RING_ROWS * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CHECK = 6'b000010,
      S_READ  = 6'b000100,
      S_DRAIN = 6'b001000,
      S_CALC  = 6'b010000,
      S_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic [15:0] noise_ff;
   logic [CW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [RW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic in_done_ff, in_done_in;
   logic [WW-1:0] wa_ff, wa_in, wb_ff, wb_in;
   logic rd_valid_ff, rd_center_ff;
   logic [13:0] sum_ff, sum_in;
   logic [21:0] sq_ff, sq_in;
   logic [7:0] p_ff, p_in;
   logic start_ff, start_in;
   logic [7:0] res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic rsp_end_ff, rsp_end_in;
   logic [CW-1:0] w_m1;
   logic [RW-1:0] h_m1;
   logic [RW:0] nr_ext;
   logic [CW:0] nc_ext;
   logic [RW-1:0] nr;
   logic [CW-1:0] nc;
   logic out_ok, accept, wr_en, last, load, cfg_hit;
   logic signed [RW+1:0] xr;
   logic signed [CW+1:0] yc;
   logic [RW-1:0] row_sel;
   logic [CW-1:0] col_sel;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0] rd_data;
   alnr_pkg::stat_req_type sreq;
   alnr_pkg::stat_rsp_type srsp;

   always_comb begin
      if (width_ff == 11'd0) w_m1 = '0;
      else if (32'(width_ff) > MAX_WIDTH) w_m1 = CW'(MAX_WIDTH - 1);
      else w_m1 = CW'(32'(width_ff) - 32'd1);
      if (height_ff == 13'd0) h_m1 = '0;
      else if (32'(height_ff) > MAX_HEIGHT) h_m1 = RW'(MAX_HEIGHT - 1);
      else h_m1 = RW'(32'(height_ff) - 32'd1);
   end

   always_comb begin
      nr_ext = (RW+1)'(out_row_ff) + (RW+1)'(HALF);
      nc_ext = (CW+1)'(out_col_ff) + (CW+1)'(HALF);
      nr = (nr_ext > (RW+1)'(h_m1)) ? h_m1 : nr_ext[RW-1:0];
      nc = (nc_ext > (CW+1)'(w_m1)) ? w_m1 : nc_ext[CW-1:0];
      out_ok = in_done_ff || (in_row_ff > nr) || ((in_row_ff == nr) && (in_col_ff > nc));
   end

   always_comb begin
      xr = signed'((RW+2)'(out_row_ff)) + signed'((RW+2)'(wa_ff)) - (RW+2)'(HALF);
      yc = signed'((CW+2)'(out_col_ff)) + signed'((CW+2)'(wb_ff)) - (CW+2)'(HALF);
      if (xr < 0) row_sel = '0;
      else if (xr > signed'((RW+2)'(h_m1))) row_sel = h_m1;
      else row_sel = xr[RW-1:0];
      if (yc < 0) col_sel = '0;
      else if (yc > signed'((CW+2)'(w_m1))) col_sel = w_m1;
      else col_sel = yc[CW-1:0];
      rd_addr = AW'(32'(row_sel[alnr_pkg::RING_W-1:0]) * MAX_WIDTH + 32'(col_sel));
      wr_addr = AW'(32'(in_row_ff[alnr_pkg::RING_W-1:0]) * MAX_WIDTH + 32'(in_col_ff));
   end

   assign cfg_hit = csr_we && (csr_index == alnr_pkg::REG_WIDTH
                    || csr_index == alnr_pkg::REG_HEIGHT || csr_index == alnr_pkg::REG_NOISE);
   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept = req_ch.valid && req_ch.ready;
   assign wr_en = accept && (req_ch.opcode == alnr_pkg::OP_SAMPLE) && !in_done_ff;
   assign last = (out_row_ff == h_m1) && (out_col_ff == w_m1);
   assign load = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in = state_ff;
      in_col_in = in_col_ff; in_row_in = in_row_ff; in_done_in = in_done_ff;
      out_col_in = out_col_ff; out_row_in = out_row_ff;
      wa_in = wa_ff; wb_in = wb_ff;
      sum_in = sum_ff; sq_in = sq_ff; p_in = p_ff;
      start_in = 1'b0;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in = rsp_data_ff; rsp_end_in = rsp_end_ff;
      if (rd_valid_ff) begin
         sum_in = sum_ff + 14'(rd_data);
         sq_in = sq_ff + 22'(16'(rd_data) * 16'(rd_data));
         if (rd_center_ff) p_in = rd_data;
      end
      if (wr_en) begin
         if (in_col_ff == w_m1) begin
            in_col_in = '0;
            if (in_row_ff == h_m1) begin
               in_row_in = '0;
               in_done_in = 1'b1;
            end else begin
               in_row_in = in_row_ff + RW'(1);
            end
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
      end
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_CHECK;
         S_CHECK: begin
            wa_in = '0; wb_in = '0; sum_in = '0; sq_in = '0;
            state_in = out_ok ? S_READ : S_IDLE;
         end
         S_READ: begin
            if (32'(wb_ff) == WINDOW - 1) begin
               wb_in = '0;
               wa_in = wa_ff + WW'(1);
               if (32'(wa_ff) == WINDOW - 1) state_in = S_DRAIN;
            end else begin
               wb_in = wb_ff + WW'(1);
            end
         end
         S_DRAIN: begin
            start_in = 1'b1;
            state_in = S_CALC;
         end
         S_CALC: begin
            if (srsp.done) begin
               res_in = srsp.value;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
               rsp_end_in = last;
               if (last) begin
                  out_col_in = '0; out_row_in = '0;
                  in_col_in = '0; in_row_in = '0; in_done_in = 1'b0;
               end else if (out_col_ff == w_m1) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + RW'(1);
               end else begin
                  out_col_in = out_col_ff + CW'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (cfg_hit) begin
         in_col_in = '0; in_row_in = '0; out_col_in = '0; out_row_in = '0;
         in_done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         width_ff <= alnr_pkg::WIDTH_RESET;
         height_ff <= alnr_pkg::HEIGHT_RESET;
         noise_ff <= alnr_pkg::NOISE_RESET;
         in_col_ff <= '0; in_row_ff <= '0; in_done_ff <= 1'b0;
         out_col_ff <= '0; out_row_ff <= '0;
         rd_valid_ff <= 1'b0; start_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we && csr_index == alnr_pkg::REG_WIDTH) width_ff <= csr_wdata[10:0];
         if (csr_we && csr_index == alnr_pkg::REG_HEIGHT) height_ff <= csr_wdata[12:0];
         if (csr_we && csr_index == alnr_pkg::REG_NOISE) noise_ff <= csr_wdata;
         in_col_ff <= in_col_in; in_row_ff <= in_row_in; in_done_ff <= in_done_in;
         out_col_ff <= out_col_in; out_row_ff <= out_row_in;
         rd_valid_ff <= (state_ff == S_READ);
         start_ff <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_center_ff <= (32'(wa_ff) == HALF) && (32'(wb_ff) == HALF);
      wa_ff <= wa_in; wb_ff <= wb_in;
      sum_ff <= sum_in; sq_ff <= sq_in; p_ff <= p_in;
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in; rsp_end_ff <= rsp_end_in;
   end

   alnr_line_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ch.sample),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign sreq.start  = start_ff;
   assign sreq.sum    = sum_ff;
   assign sreq.sumsq  = sq_ff;
   assign sreq.center = p_ff;
   assign sreq.noise  = noise_ff;

   alnr_stat #(.TAPS(TAPS)) u_stat (
      .clock (clock),
      .reset (reset),
      .req   (sreq),
      .rsp   (srsp)
   );

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_sample = rsp_data_ff;
   assign rsp_ch.frame_end  = rsp_end_ff;

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      out_col_ff <= w_m1 && in_col_ff <= w_m1)
      else $error("column position beyond row width");
   a_done_pos: assert property (@(posedge clock) disable iff (reset)
      in_done_ff |-> (in_row_ff == '0 && in_col_ff == '0))
      else $error("input position not cleared at frame end");
   a_stat_done: assert property (@(posedge clock) disable iff (reset)
      srsp.done |-> state_ff == S_CALC)
      else $error("statistics result outside calculation state");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("loaded result not presented");
endmodule

/* tb/adaptive_local_noise_reduction_unit_tb.sv */
// Self-checking testbench of the adaptive local noise reduction unit.
module adaptive_local_noise_reduction_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W = 1024;
   localparam int MAX_H = 4096;
   localparam int HALF = 3;
   localparam int TAPS = 49;
   localparam int SETTLE = 100;
   localparam int STALL_LIMIT = 5000;
   localparam int SAMPLE_GOAL = 1150;

   typedef struct {
      logic [7:0] px;
      logic       fe;
   } pixel_type;

   typedef struct {
      bit                       is_csr;
      bit [alnr_pkg::IDX_W-1:0] idx;
      bit [15:0]                val;
      bit                       op;
      bit [7:0]                 smp;
      bit                       typed;
      bit [7:0]                 exp_px;
      bit                       exp_end;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [alnr_pkg::IDX_W-1:0] csr_index;
   logic [alnr_pkg::CSR_W-1:0] csr_wdata;

   alnr_req_if req_bus ();
   alnr_rsp_if rsp_bus ();

   adaptive_local_noise_reduction_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pixel_type expected_px[$];
   int err_count = 0;
   int samples_sent = 0;
   int stall_cycles = 0;
   bit calm = 0;

   logic [7:0] line_copy [8*MAX_W];
   int width_reg, height_reg, noise_reg;
   int in_row, in_col, out_row, out_col;
   bit in_done;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      err_count++;
   endtask

   function automatic int eff_width();
      if (width_reg < 1) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
   endfunction

   function automatic int eff_height();
      if (height_reg < 1) return 1;
      if (height_reg > MAX_H) return MAX_H;
      return height_reg;
   endfunction

   function automatic void restart_frame();
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
      in_done = 0;
   endfunction

   function automatic bit frame_idle();
      return !in_done && in_row == 0 && in_col == 0 && out_row == 0 && out_col == 0;
   endfunction

   function automatic bit output_ready();
      int w, h, nr, nc;
      w = eff_width();
      h = eff_height();
      if (in_done) return 1;
      nr = (out_row + HALF > h - 1) ? h - 1 : out_row + HALF;
      nc = (out_col + HALF > w - 1) ? w - 1 : out_col + HALF;
      return longint'(in_row) * w + in_col > longint'(nr) * w + nc;
   endfunction

   function automatic pixel_type filter_pixel();
      int w, h, x, y, sum, m, d, p;
      longint s, gn, num, res;
      pixel_type r;
      logic [7:0] win [TAPS];
      w = eff_width();
      h = eff_height();
      sum = 0;
      for (int a = -HALF; a <= HALF; a++) begin
         x = out_row + a;
         if (x < 0) x = 0;
         if (x > h - 1) x = h - 1;
         for (int b = -HALF; b <= HALF; b++) begin
            y = out_col + b;
            if (y < 0) y = 0;
            if (y > w - 1) y = w - 1;
            win[(a + HALF) * 7 + b + HALF] = line_copy[(x % 8) * MAX_W + y];
            sum += line_copy[(x % 8) * MAX_W + y];
         end
      end
      m = sum / TAPS;
      s = 0;
      for (int k = 0; k < TAPS; k++) begin
         d = int'(win[k]) - m;
         s += d * d;
      end
      p = win[HALF * 7 + HALF];
      gn = longint'(noise_reg) * TAPS;
      if (gn > s) res = m;
      else if (s == 0) res = p;
      else begin
         num = longint'(p) * s - gn * (p - m);
         if (num < 0) num = 0;
         res = num / s;
         if (res > 255) res = 255;
      end
      r.px = res[7:0];
      r.fe = (out_row + 1 >= h) && (out_col + 1 >= w);
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
      if (r.fe) restart_frame();
      return r;
   endfunction

   function automatic bit filter_step(input logic op, input logic [7:0] smp,
                                      output pixel_type r);
      int w, h;
      w = eff_width();
      h = eff_height();
      if (op == alnr_pkg::OP_SAMPLE && !in_done) begin
         if (in_col >= w) in_col = w - 1;
         line_copy[(in_row % 8) * MAX_W + in_col] = smp;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) begin
               in_row = 0;
               in_done = 1;
            end
         end
      end
      if (!output_ready()) return 0;
      r = filter_pixel();
      return 1;
   endfunction

   task automatic send_item(input logic op, input logic [7:0] smp, input bit typed = 0,
                            input logic [7:0] exp_px = 0, input logic exp_end = 0);
      pixel_type r;
      bit got;
      @(negedge clock);
      while (!calm && $urandom_range(99) < 15) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.opcode = op;
      req_bus.sample = smp;
      forever begin
         @(posedge clock);
         if (req_bus.ready) break;
      end
      samples_sent++;
      got = filter_step(op, smp, r);
      if (typed) begin
         if (!got) report_mismatch("table row expects a pixel the filter does not produce");
         r.px = exp_px;
         r.fe = exp_end;
      end
      if (got) expected_px.push_back(r);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_px.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [alnr_pkg::IDX_W-1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         alnr_pkg::REG_WIDTH: width_reg = val[10:0];
         alnr_pkg::REG_HEIGHT: height_reg = val[12:0];
         alnr_pkg::REG_NOISE: noise_reg = val;
         default: ;
      endcase
      restart_frame();
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic drain_frame();
      int guard;
      guard = 0;
      while (!frame_idle() && guard < 20000) begin
         if ($urandom_range(1)) send_item(alnr_pkg::OP_FLUSH, 8'($urandom_range(255)));
         else send_item(alnr_pkg::OP_SAMPLE, 8'($urandom_range(255)));
         guard++;
      end
   endtask

   function automatic logic [7:0] pick_sample(input int style, input int base);
      case (style)
         0: return base[7:0];
         1: return $urandom_range(1) ? 8'hFF : 8'h00;
         2: return 8'($urandom_range(base + 12 > 255 ? 255 : base + 12,
                                      base < 12 ? 0 : base - 12));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic run_frames(input int count, input int cutoff, input bool_pause);
      int total, style, base;
      for (int f = 0; f < count; f++) begin
         total = eff_width() * eff_height();
         if (cutoff > 0 && cutoff < total) total = cutoff;
         style = $urandom_range(3);
         base = $urandom_range(255);
         for (int i = 0; i < total; i++) begin
            if ($urandom_range(9) == 0)
               send_item(alnr_pkg::OP_FLUSH, 8'($urandom_range(255)));
            if (bool_pause && i == total / 2) wait_idle();
            send_item(alnr_pkg::OP_SAMPLE, pick_sample(style, base));
         end
         if (cutoff > 0) return;
         drain_frame();
      end
   endtask

   initial begin
      stim_row_type table_rows [] = '{
         '{1, alnr_pkg::REG_WIDTH, 1, 0, 0, 0, 0, 0},
         '{1, alnr_pkg::REG_HEIGHT, 1, 0, 0, 0, 0, 0},
         '{1, alnr_pkg::REG_NOISE, 1000, 0, 0, 0, 0, 0},
         '{0, 0, 0, alnr_pkg::OP_SAMPLE, 8'd0, 1, 8'd0, 1},
         '{0, 0, 0, alnr_pkg::OP_SAMPLE, 8'd255, 1, 8'd255, 1},
         '{0, 0, 0, alnr_pkg::OP_FLUSH, 8'd255, 0, 0, 0},
         '{1, alnr_pkg::REG_NOISE, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, alnr_pkg::OP_SAMPLE, 8'd200, 1, 8'd200, 1},
         '{1, alnr_pkg::REG_WIDTH, 0, 0, 0, 0, 0, 0},
         '{1, alnr_pkg::REG_HEIGHT, 0, 0, 0, 0, 0, 0},
         '{1, alnr_pkg::REG_NOISE, 16'hFFFF, 0, 0, 0, 0, 0},
         '{0, 0, 0, alnr_pkg::OP_SAMPLE, 8'd77, 1, 8'd77, 1},
         '{1, alnr_pkg::REG_WIDTH, 4, 0, 0, 0, 0, 0},
         '{1, alnr_pkg::REG_HEIGHT, 3, 0, 0, 0, 0, 0},
         '{1, alnr_pkg::REG_NOISE, 500, 0, 0, 0, 0, 0},
         '{0, 0, 0, alnr_pkg::OP_SAMPLE, 8'd0, 0, 0, 0},
         '{0, 0, 0, alnr_pkg::OP_SAMPLE, 8'd255, 0, 0, 0},
         '{0, 0, 0, alnr_pkg::OP_SAMPLE, 8'd0, 0, 0, 0},
         '{0, 0, 0, alnr_pkg::OP_SAMPLE, 8'd255, 0, 0, 0},
         '{0, 0, 0, alnr_pkg::OP_SAMPLE, 8'd10, 0, 0, 0},
         '{0, 0, 0, alnr_pkg::OP_SAMPLE, 8'd20, 0, 0, 0},
         '{0, 0, 0, alnr_pkg::OP_SAMPLE, 8'd30, 0, 0, 0},
         '{0, 0, 0, alnr_pkg::OP_SAMPLE, 8'd40, 0, 0, 0},
         '{0, 0, 0, alnr_pkg::OP_SAMPLE, 8'd255, 0, 0, 0},
         '{0, 0, 0, alnr_pkg::OP_SAMPLE, 8'd255, 0, 0, 0},
         '{0, 0, 0, alnr_pkg::OP_SAMPLE, 8'd0, 0, 0, 0},
         '{0, 0, 0, alnr_pkg::OP_SAMPLE, 8'd0, 0, 0, 0},
         '{0, 0, 0, alnr_pkg::OP_SAMPLE, 8'd99, 0, 0, 0},
         '{0, 0, 0, alnr_pkg::OP_FLUSH, 8'd0, 0, 0, 0},
         '{0, 0, 0, alnr_pkg::OP_SAMPLE, 8'd1, 0, 0, 0}
      };
      int kind, phase, noise_pick;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = alnr_pkg::OP_SAMPLE;
      req_bus.sample = '0;
      width_reg = alnr_pkg::WIDTH_RESET;
      height_reg = alnr_pkg::HEIGHT_RESET;
      noise_reg = alnr_pkg::NOISE_RESET;
      restart_frame();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (table_rows[i]) begin
         if (table_rows[i].is_csr) begin
            wait_idle();
            write_csr(table_rows[i].idx, table_rows[i].val);
         end else begin
            send_item(table_rows[i].op, table_rows[i].smp, table_rows[i].typed,
                      table_rows[i].exp_px, table_rows[i].exp_end);
         end
      end
      drain_frame();

      phase = 0;
      while (samples_sent < SAMPLE_GOAL) begin
         calm = samples_sent >= 400 && samples_sent < 600;
         wait_idle();
         kind = $urandom_range(19);
         noise_pick = $urandom_range(3);
         case (noise_pick)
            0: write_csr(alnr_pkg::REG_NOISE, 16'd0);
            1: write_csr(alnr_pkg::REG_NOISE, 16'hFFFF);
            2: write_csr(alnr_pkg::REG_NOISE, 16'($urandom_range(2000)));
            default: write_csr(alnr_pkg::REG_NOISE, 16'($urandom_range(16'hFFFF)));
         endcase
         if (kind == 0 || phase == 3) begin
            write_csr(alnr_pkg::REG_HEIGHT, 16'd1);
            write_csr(alnr_pkg::REG_WIDTH, 16'h7FF);
            run_frames(1, 40, 0);
         end else if (kind == 1 || phase == 5) begin
            write_csr(alnr_pkg::REG_WIDTH, 16'd1);
            write_csr(alnr_pkg::REG_HEIGHT, 16'h1FFF);
            run_frames(1, 40, 0);
         end else begin
            write_csr(alnr_pkg::REG_WIDTH,
                      16'($urandom_range(15) == 0 ? 0 : $urandom_range(10, 1)));
            write_csr(alnr_pkg::REG_HEIGHT,
                      16'($urandom_range(15) == 0 ? 0 : $urandom_range(8, 1)));
            run_frames($urandom_range(3, 1),
                       $urandom_range(7) == 0 ? $urandom_range(20, 1) : 0,
                       phase == 0 || $urandom_range(3) == 0);
         end
         phase++;
      end
      calm = 0;

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_px.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (err_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   always @(negedge clock) begin
      if (calm) rsp_bus.ready = 1'b1;
      else rsp_bus.ready = $urandom_range(99) >= 15;
   end

   initial rsp_bus.ready = 1'b0;

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_px.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel %0d", rsp_bus.out_sample));
         end else begin
            want = expected_px.pop_front();
            if (rsp_bus.out_sample !== want.px)
               report_mismatch($sformatf("out_sample %0d, expected %0d",
                                         rsp_bus.out_sample, want.px));
            if (rsp_bus.frame_end !== want.fe)
               report_mismatch($sformatf("frame_end %0b, expected %0b",
                                         rsp_bus.frame_end, want.fe));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || csr_we) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

endmodule

/* files.f */
design/alnr_pkg.sv
design/alnr_if.sv
design/alnr_line_mem.sv
design/alnr_stat.sv
design/adaptive_local_noise_reduction_unit.sv
tb/adaptive_local_noise_reduction_unit_tb.sv
